// File: rtl/core/chc_pkg.sv
// shared types, codes and register defaults of the climate hysteresis controller
`default_nettype none

package chc_pkg;

  // field widths
  localparam int HumW  = 10;
  localparam int TempW = 12;
  localparam int ActW  = 3;
  localparam int CmdW  = 2;
  localparam int ModeW = 2;
  localparam int AddrW = 5;
  localparam int DataW = 32;

  // event codes
  localparam logic [ActW-1:0] ACT_SENSOR    = 3'd0;
  localparam logic [ActW-1:0] ACT_DELAY_EXP = 3'd1;
  localparam logic [ActW-1:0] ACT_RUN_EXP   = 3'd2;
  localparam logic [ActW-1:0] ACT_VENT_BTN  = 3'd3;
  localparam logic [ActW-1:0] ACT_STOP_BTN  = 3'd4;
  localparam logic [ActW-1:0] ACT_RESET     = 3'd5;

  // timer commands
  localparam logic [CmdW-1:0] CMD_NONE  = 2'd0;
  localparam logic [CmdW-1:0] CMD_START = 2'd1;
  localparam logic [CmdW-1:0] CMD_STOP  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_HUMIDIFY_ON_BELOW  = 3'd0;
  localparam logic [2:0] REG_HUMIDIFY_OFF_ABOVE = 3'd1;
  localparam logic [2:0] REG_DRY_OFF_BELOW      = 3'd2;
  localparam logic [2:0] REG_DRY_ON_ABOVE       = 3'd3;
  localparam logic [2:0] REG_HEAT_ON_BELOW      = 3'd4;
  localparam logic [2:0] REG_HEAT_OFF_ABOVE     = 3'd5;
  localparam logic [2:0] REG_COOL_OFF_BELOW     = 3'd6;
  localparam logic [2:0] REG_COOL_ON_ABOVE      = 3'd7;

  // register reset values
  localparam logic [HumW-1:0]         RST_HUMIDIFY_ON_BELOW  = 10'd600;
  localparam logic [HumW-1:0]         RST_HUMIDIFY_OFF_ABOVE = 10'd650;
  localparam logic [HumW-1:0]         RST_DRY_OFF_BELOW      = 10'd750;
  localparam logic [HumW-1:0]         RST_DRY_ON_ABOVE       = 10'd800;
  localparam logic signed [TempW-1:0] RST_HEAT_ON_BELOW      = 12'sd200;
  localparam logic signed [TempW-1:0] RST_HEAT_OFF_ABOVE     = 12'sd230;
  localparam logic signed [TempW-1:0] RST_COOL_OFF_BELOW     = 12'sd260;
  localparam logic signed [TempW-1:0] RST_COOL_ON_ABOVE      = 12'sd290;

  // threshold set
  typedef struct packed {
    logic [HumW-1:0]         humidify_on_below;
    logic [HumW-1:0]         humidify_off_above;
    logic [HumW-1:0]         dry_off_below;
    logic [HumW-1:0]         dry_on_above;
    logic signed [TempW-1:0] heat_on_below;
    logic signed [TempW-1:0] heat_off_above;
    logic signed [TempW-1:0] cool_off_below;
    logic signed [TempW-1:0] cool_on_above;
  } thresh_t;

  // humidity machine outcome for one word
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [CmdW-1:0]  delay_cmd;
    logic [CmdW-1:0]  run_cmd;
    logic             handled;
  } hum_res_t;

endpackage

`default_nettype wire

// File: rtl/core/chc_cfg.sv
// threshold registers behind the apb-style configuration port
`default_nettype none

module chc_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [chc_pkg::AddrW-1:0]   paddr,
  input  wire logic [chc_pkg::DataW-1:0]   pwdata,
  output logic      [chc_pkg::DataW-1:0]   prdata,
  output logic                             pready,
  output chc_pkg::thresh_t                 thresh
);
  import chc_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh.humidify_on_below  <= RST_HUMIDIFY_ON_BELOW;
      thresh.humidify_off_above <= RST_HUMIDIFY_OFF_ABOVE;
      thresh.dry_off_below      <= RST_DRY_OFF_BELOW;
      thresh.dry_on_above       <= RST_DRY_ON_ABOVE;
      thresh.heat_on_below      <= RST_HEAT_ON_BELOW;
      thresh.heat_off_above     <= RST_HEAT_OFF_ABOVE;
      thresh.cool_off_below     <= RST_COOL_OFF_BELOW;
      thresh.cool_on_above      <= RST_COOL_ON_ABOVE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HUMIDIFY_ON_BELOW:  thresh.humidify_on_below  <= pwdata[HumW-1:0];
        REG_HUMIDIFY_OFF_ABOVE: thresh.humidify_off_above <= pwdata[HumW-1:0];
        REG_DRY_OFF_BELOW:      thresh.dry_off_below      <= pwdata[HumW-1:0];
        REG_DRY_ON_ABOVE:       thresh.dry_on_above       <= pwdata[HumW-1:0];
        REG_HEAT_ON_BELOW:      thresh.heat_on_below      <= signed'(pwdata[TempW-1:0]);
        REG_HEAT_OFF_ABOVE:     thresh.heat_off_above     <= signed'(pwdata[TempW-1:0]);
        REG_COOL_OFF_BELOW:     thresh.cool_off_below     <= signed'(pwdata[TempW-1:0]);
        REG_COOL_ON_ABOVE:      thresh.cool_on_above      <= signed'(pwdata[TempW-1:0]);
        default: ;
      endcase
    end
  end

  // read back, temperatures sign-extended
  always_comb begin
    case (reg_idx)
      REG_HUMIDIFY_ON_BELOW:  prdata = {{(DataW-HumW){1'b0}}, thresh.humidify_on_below};
      REG_HUMIDIFY_OFF_ABOVE: prdata = {{(DataW-HumW){1'b0}}, thresh.humidify_off_above};
      REG_DRY_OFF_BELOW:      prdata = {{(DataW-HumW){1'b0}}, thresh.dry_off_below};
      REG_DRY_ON_ABOVE:       prdata = {{(DataW-HumW){1'b0}}, thresh.dry_on_above};
      REG_HEAT_ON_BELOW:
        prdata = {{(DataW-TempW){thresh.heat_on_below[TempW-1]}}, thresh.heat_on_below};
      REG_HEAT_OFF_ABOVE:
        prdata = {{(DataW-TempW){thresh.heat_off_above[TempW-1]}}, thresh.heat_off_above};
      REG_COOL_OFF_BELOW:
        prdata = {{(DataW-TempW){thresh.cool_off_below[TempW-1]}}, thresh.cool_off_below};
      REG_COOL_ON_ABOVE:
        prdata = {{(DataW-TempW){thresh.cool_on_above[TempW-1]}}, thresh.cool_on_above};
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/chc_hum_fsm.sv
// humidity hysteresis machine with idle ventilation timer control
`default_nettype none

module chc_hum_fsm (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      advance,
  input  wire logic [chc_pkg::ActW-1:0]  action,
  input  wire logic [chc_pkg::HumW-1:0]  humidity,
  input  wire chc_pkg::thresh_t          thresh,
  output chc_pkg::hum_res_t              res
);
  import chc_pkg::*;

  typedef enum logic [ModeW-1:0] {
    HM_HUMID = 2'd0,
    HM_IDLE  = 2'd1,
    HM_VENT  = 2'd2,
    HM_DRY   = 2'd3
  } hum_mode_t;

  hum_mode_t       mode, mode_next;
  logic [CmdW-1:0] dcmd, rcmd;
  logic            hit;
  logic            below_on, above_on;

  assign below_on = humidity < thresh.humidify_on_below;
  assign above_on = humidity > thresh.dry_on_above;

  // next mode and timer commands for the word in the input register
  always_comb begin
    mode_next = mode;
    dcmd      = CMD_NONE;
    rcmd      = CMD_NONE;
    hit       = 1'b0;
    case (action)
      ACT_RESET: begin
        if (mode == HM_VENT) rcmd = CMD_STOP;
        dcmd      = CMD_START;
        mode_next = HM_IDLE;
        hit       = 1'b1;
      end
      ACT_SENSOR: begin
        case (mode)
          HM_HUMID: begin
            if (humidity > thresh.humidify_off_above) begin
              mode_next = HM_IDLE;
              dcmd      = CMD_START;
              hit       = 1'b1;
            end
          end
          HM_DRY: begin
            if (humidity < thresh.dry_off_below) begin
              mode_next = HM_IDLE;
              dcmd      = CMD_START;
              hit       = 1'b1;
            end
          end
          default: begin
            // humidifying test wins over drying in both idle sub-modes
            if (below_on || above_on) begin
              mode_next = below_on ? HM_HUMID : HM_DRY;
              hit       = 1'b1;
              if (mode == HM_IDLE) dcmd = CMD_STOP;
              else rcmd = CMD_STOP;
            end
          end
        endcase
      end
      ACT_DELAY_EXP, ACT_VENT_BTN: begin
        if (mode == HM_IDLE) begin
          mode_next = HM_VENT;
          dcmd      = CMD_STOP;
          rcmd      = CMD_START;
          hit       = 1'b1;
        end
      end
      ACT_RUN_EXP, ACT_STOP_BTN: begin
        if (mode == HM_VENT) begin
          mode_next = HM_IDLE;
          rcmd      = CMD_STOP;
          dcmd      = CMD_START;
          hit       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res.mode      = mode_next;
  assign res.delay_cmd = dcmd;
  assign res.run_cmd   = rcmd;
  assign res.handled   = hit;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= HM_IDLE;
    end else if (advance) begin
      mode <= mode_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/chc_temp_fsm.sv
// temperature hysteresis machine
`default_nettype none

module chc_temp_fsm (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              advance,
  input  wire logic [chc_pkg::ActW-1:0]          action,
  input  wire logic signed [chc_pkg::TempW-1:0]  temperature,
  input  wire chc_pkg::thresh_t                  thresh,
  output logic [chc_pkg::ModeW-1:0]              mode_out
);
  import chc_pkg::*;

  typedef enum logic [ModeW-1:0] {
    TM_IDLE = 2'd0,
    TM_HEAT = 2'd1,
    TM_COOL = 2'd2
  } temp_mode_t;

  temp_mode_t mode, mode_next;

  // next mode, heating checked before cooling when idle
  always_comb begin
    mode_next = mode;
    if (action == ACT_RESET) begin
      mode_next = TM_IDLE;
    end else if (action == ACT_SENSOR) begin
      case (mode)
        TM_IDLE: begin
          if (temperature < thresh.heat_on_below) mode_next = TM_HEAT;
          else if (temperature > thresh.cool_on_above) mode_next = TM_COOL;
        end
        TM_HEAT: begin
          if (temperature > thresh.heat_off_above) mode_next = TM_IDLE;
        end
        default: begin
          if (temperature < thresh.cool_off_below) mode_next = TM_IDLE;
        end
      endcase
    end
  end

  assign mode_out = mode_next;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= TM_IDLE;
    end else if (advance) begin
      mode <= mode_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/climate_hysteresis_controller.sv
// top level of the climate hysteresis controller
`default_nettype none

// Each event word (sensor update, timer expiry, button or reset) is taken
// into an input register; the humidity and temperature machines then work
// out the new modes, relay levels and ventilation timer commands by comparing
// against the threshold registers, and the result lands in an output register.
// One word is accepted every clock cycle while results are taken; a held result
// stalls the next word in the input register until the output register frees up.
// Thresholds are written through the APB-style port (registers at 4*index)
// and must only change while no word is in flight. All comparisons are
// strict, humidity unsigned in 0.1 %RH, temperature signed in 0.1 degC.
module climate_hysteresis_controller (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [chc_pkg::AddrW-1:0]         paddr,
  input  wire logic [chc_pkg::DataW-1:0]         pwdata,
  output logic      [chc_pkg::DataW-1:0]         prdata,
  output logic                                   pready,
  // event words
  input  wire logic                              evt_valid,
  output logic                                   evt_ready,
  input  wire logic [chc_pkg::ActW-1:0]          action,
  input  wire logic [chc_pkg::HumW-1:0]          humidity,
  input  wire logic signed [chc_pkg::TempW-1:0]  temperature,
  // result words
  output logic                                   res_valid,
  input  wire logic                              res_ready,
  output logic                                   humidifier_on,
  output logic                                   dryer_on,
  output logic                                   ventilator_on,
  output logic                                   heater_on,
  output logic                                   cooler_on,
  output logic [chc_pkg::CmdW-1:0]               delay_timer_cmd,
  output logic [chc_pkg::CmdW-1:0]               run_timer_cmd,
  output logic [chc_pkg::ModeW-1:0]              humidity_mode,
  output logic [chc_pkg::ModeW-1:0]              temperature_mode,
  output logic                                   handled
);
  import chc_pkg::*;

  localparam logic [ModeW-1:0] HUM_HUMID = 2'd0;
  localparam logic [ModeW-1:0] HUM_VENT  = 2'd2;
  localparam logic [ModeW-1:0] HUM_DRY   = 2'd3;
  localparam logic [ModeW-1:0] TMP_HEAT  = 2'd1;
  localparam logic [ModeW-1:0] TMP_COOL  = 2'd2;

  thresh_t                 thresh;
  hum_res_t                hum_res;
  logic [ModeW-1:0]        tmp_mode;

  logic                    in_full;
  logic [ActW-1:0]         in_action;
  logic [HumW-1:0]         in_humidity;
  logic signed [TempW-1:0] in_temperature;
  logic                    advance;

  // word moves on when the output register is free or being emptied
  assign advance   = in_full && (!res_valid || res_ready);
  assign evt_ready = !in_full || advance;

  chc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thresh  (thresh)
  );

  chc_hum_fsm u_hum (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .action   (in_action),
    .humidity (in_humidity),
    .thresh   (thresh),
    .res      (hum_res)
  );

  chc_temp_fsm u_temp (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .action      (in_action),
    .temperature (in_temperature),
    .thresh      (thresh),
    .mode_out    (tmp_mode)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (evt_ready) begin
      in_full <= evt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      in_action      <= action;
      in_humidity    <= humidity;
      in_temperature <= temperature;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      humidifier_on    <= hum_res.mode == HUM_HUMID;
      dryer_on         <= hum_res.mode == HUM_DRY;
      ventilator_on    <= hum_res.mode == HUM_VENT;
      heater_on        <= tmp_mode == TMP_HEAT;
      cooler_on        <= tmp_mode == TMP_COOL;
      delay_timer_cmd  <= hum_res.delay_cmd;
      run_timer_cmd    <= hum_res.run_cmd;
      humidity_mode    <= hum_res.mode;
      temperature_mode <= tmp_mode;
      handled          <= hum_res.handled;
    end
  end

endmodule

`default_nettype wire

// File: test/climate_result_checker.sv
// checker for the climate hysteresis controller: predicts each result word and compares it
`timescale 1ns / 100ps

module climate_result_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [chc_pkg::AddrW-1:0]         paddr,
  input  logic [chc_pkg::DataW-1:0]         pwdata,
  input  logic                              evt_valid,
  input  logic                              evt_ready,
  input  logic [chc_pkg::ActW-1:0]          action,
  input  logic [chc_pkg::HumW-1:0]          humidity,
  input  logic signed [chc_pkg::TempW-1:0]  temperature,
  input  logic                              res_valid,
  input  logic                              res_ready,
  input  logic                              humidifier_on,
  input  logic                              dryer_on,
  input  logic                              ventilator_on,
  input  logic                              heater_on,
  input  logic                              cooler_on,
  input  logic [chc_pkg::CmdW-1:0]          delay_timer_cmd,
  input  logic [chc_pkg::CmdW-1:0]          run_timer_cmd,
  input  logic [chc_pkg::ModeW-1:0]         humidity_mode,
  input  logic [chc_pkg::ModeW-1:0]         temperature_mode,
  input  logic                              handled,
  output int                                mismatches,
  output int                                pending
);
  import chc_pkg::*;

  localparam int PRINT_LIMIT = 40;

  typedef enum logic [ModeW-1:0] {
    H_HUMIDIFYING = 2'd0,
    H_IDLE        = 2'd1,
    H_VENTING     = 2'd2,
    H_DRYING      = 2'd3
  } hum_mode_e;

  typedef enum logic [ModeW-1:0] {
    T_IDLE    = 2'd0,
    T_HEATING = 2'd1,
    T_COOLING = 2'd2
  } temp_mode_e;

  typedef struct packed {
    logic             humidifier;
    logic             dryer;
    logic             ventilator;
    logic             heater;
    logic             cooler;
    logic [CmdW-1:0]  delay_cmd;
    logic [CmdW-1:0]  run_cmd;
    logic [ModeW-1:0] hum_mode;
    logic [ModeW-1:0] temp_mode;
    logic             handled;
  } climate_word_t;

  thresh_t       limits;
  hum_mode_e     hum_state;
  temp_mode_e    temp_state;
  climate_word_t expected_words[$];
  climate_word_t want;
  climate_word_t got;
  int            fail_count;

  // one event applied to both hysteresis machines
  function automatic climate_word_t next_climate_word(
    input logic [ActW-1:0]          act,
    input logic [HumW-1:0]          hum,
    input logic signed [TempW-1:0]  tmp,
    input hum_mode_e                hm,
    input temp_mode_e               tm,
    input thresh_t                  lim
  );
    climate_word_t w;
    hum_mode_e     hn;
    temp_mode_e    tn;
    hn = hm;
    tn = tm;
    w = '0;
    w.delay_cmd = CMD_NONE;
    w.run_cmd = CMD_NONE;
    case (act)
      ACT_RESET: begin
        if (hm == H_VENTING) w.run_cmd = CMD_STOP;
        w.delay_cmd = CMD_START;
        hn = H_IDLE;
        tn = T_IDLE;
        w.handled = 1'b1;
      end
      ACT_SENSOR: begin
        // humidity side
        case (hm)
          H_HUMIDIFYING: begin
            if (hum > lim.humidify_off_above) begin
              hn = H_IDLE;
              w.delay_cmd = CMD_START;
              w.handled = 1'b1;
            end
          end
          H_DRYING: begin
            if (hum < lim.dry_off_below) begin
              hn = H_IDLE;
              w.delay_cmd = CMD_START;
              w.handled = 1'b1;
            end
          end
          default: begin
            // humidifying wins over drying when both hold
            if (hum < lim.humidify_on_below) hn = H_HUMIDIFYING;
            else if (hum > lim.dry_on_above) hn = H_DRYING;
            if (hn != hm) begin
              if (hm == H_IDLE) w.delay_cmd = CMD_STOP;
              else w.run_cmd = CMD_STOP;
              w.handled = 1'b1;
            end
          end
        endcase
        // temperature side, heating tested first
        case (tm)
          T_IDLE: begin
            if ($signed(tmp) < $signed(lim.heat_on_below)) tn = T_HEATING;
            else if ($signed(tmp) > $signed(lim.cool_on_above)) tn = T_COOLING;
          end
          T_HEATING: begin
            if ($signed(tmp) > $signed(lim.heat_off_above)) tn = T_IDLE;
          end
          default: begin
            if ($signed(tmp) < $signed(lim.cool_off_below)) tn = T_IDLE;
          end
        endcase
      end
      ACT_DELAY_EXP, ACT_VENT_BTN: begin
        if (hm == H_IDLE) begin
          hn = H_VENTING;
          w.delay_cmd = CMD_STOP;
          w.run_cmd = CMD_START;
          w.handled = 1'b1;
        end
      end
      ACT_RUN_EXP, ACT_STOP_BTN: begin
        if (hm == H_VENTING) begin
          hn = H_IDLE;
          w.run_cmd = CMD_STOP;
          w.delay_cmd = CMD_START;
          w.handled = 1'b1;
        end
      end
      default: ;
    endcase
    w.humidifier = (hn == H_HUMIDIFYING);
    w.dryer = (hn == H_DRYING);
    w.ventilator = (hn == H_VENTING);
    w.heater = (tn == T_HEATING);
    w.cooler = (tn == T_COOLING);
    w.hum_mode = hn;
    w.temp_mode = tn;
    return w;
  endfunction

  task automatic check_field(input string field, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      if (fail_count < PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val,
                 act_val);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      limits = {RST_HUMIDIFY_ON_BELOW, RST_HUMIDIFY_OFF_ABOVE, RST_DRY_OFF_BELOW,
                RST_DRY_ON_ABOVE, RST_HEAT_ON_BELOW, RST_HEAT_OFF_ABOVE,
                RST_COOL_OFF_BELOW, RST_COOL_ON_ABOVE};
      hum_state = H_IDLE;
      temp_state = T_IDLE;
      expected_words.delete();
    end else begin
      // threshold writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_HUMIDIFY_ON_BELOW:  limits.humidify_on_below = pwdata[HumW-1:0];
          REG_HUMIDIFY_OFF_ABOVE: limits.humidify_off_above = pwdata[HumW-1:0];
          REG_DRY_OFF_BELOW:      limits.dry_off_below = pwdata[HumW-1:0];
          REG_DRY_ON_ABOVE:       limits.dry_on_above = pwdata[HumW-1:0];
          REG_HEAT_ON_BELOW:      limits.heat_on_below = pwdata[TempW-1:0];
          REG_HEAT_OFF_ABOVE:     limits.heat_off_above = pwdata[TempW-1:0];
          REG_COOL_OFF_BELOW:     limits.cool_off_below = pwdata[TempW-1:0];
          REG_COOL_ON_ABOVE:      limits.cool_on_above = pwdata[TempW-1:0];
          default: ;
        endcase
      end
      // accepted event word
      if (evt_valid && evt_ready) begin
        want = next_climate_word(action, humidity, temperature, hum_state, temp_state,
                                 limits);
        hum_state = hum_mode_e'(want.hum_mode);
        temp_state = temp_mode_e'(want.temp_mode);
        expected_words.push_back(want);
      end
      // accepted result word
      if (res_valid && res_ready) begin
        if (expected_words.size() == 0) begin
          if (fail_count < PRINT_LIMIT)
            $display("%0t: result word with nothing expected, expected none, actual mode %0d/%0d",
                     $time, humidity_mode, temperature_mode);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          got = {humidifier_on, dryer_on, ventilator_on, heater_on, cooler_on,
                 delay_timer_cmd, run_timer_cmd, humidity_mode, temperature_mode, handled};
          check_field("humidifier_on", want.humidifier, got.humidifier);
          check_field("dryer_on", want.dryer, got.dryer);
          check_field("ventilator_on", want.ventilator, got.ventilator);
          check_field("heater_on", want.heater, got.heater);
          check_field("cooler_on", want.cooler, got.cooler);
          check_field("delay_timer_cmd", want.delay_cmd, got.delay_cmd);
          check_field("run_timer_cmd", want.run_cmd, got.run_cmd);
          check_field("humidity_mode", want.hum_mode, got.hum_mode);
          check_field("temperature_mode", want.temp_mode, got.temp_mode);
          check_field("handled", want.handled, got.handled);
        end
      end
    end
    pending <= expected_words.size();
    mismatches <= fail_count;
  end

endmodule

// File: test/tb_climate_hysteresis_controller.sv
// testbench top: event and threshold stimulus for the climate hysteresis controller
`timescale 1ns / 100ps

module tb_climate_hysteresis_controller;
  import chc_pkg::*;

  // action codes the block ignores
  localparam logic [ActW-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ActW-1:0] ACT_SPARE_HI = 3'd7;
  localparam int HOLD_CYCLES = 80;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [AddrW-1:0]         paddr;
  logic [DataW-1:0]         pwdata;
  logic [DataW-1:0]         prdata;
  logic                     pready;
  logic                     evt_valid;
  logic                     evt_ready;
  logic [ActW-1:0]          action;
  logic [HumW-1:0]          humidity;
  logic signed [TempW-1:0]  temperature;
  logic                     res_valid;
  logic                     res_ready;
  logic                     humidifier_on;
  logic                     dryer_on;
  logic                     ventilator_on;
  logic                     heater_on;
  logic                     cooler_on;
  logic [CmdW-1:0]          delay_timer_cmd;
  logic [CmdW-1:0]          run_timer_cmd;
  logic [ModeW-1:0]         humidity_mode;
  logic [ModeW-1:0]         temperature_mode;
  logic                     handled;

  int      mismatches;
  int      pending;
  bit      idle_en;
  bit      hold_req;
  int      words_sent;
  int      settings_run;
  thresh_t limits_now;

  climate_hysteresis_controller dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .evt_valid(evt_valid), .evt_ready(evt_ready),
    .action(action), .humidity(humidity), .temperature(temperature),
    .res_valid(res_valid), .res_ready(res_ready),
    .humidifier_on(humidifier_on), .dryer_on(dryer_on), .ventilator_on(ventilator_on),
    .heater_on(heater_on), .cooler_on(cooler_on),
    .delay_timer_cmd(delay_timer_cmd), .run_timer_cmd(run_timer_cmd),
    .humidity_mode(humidity_mode), .temperature_mode(temperature_mode),
    .handled(handled)
  );

  climate_result_checker results_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .evt_valid(evt_valid), .evt_ready(evt_ready),
    .action(action), .humidity(humidity), .temperature(temperature),
    .res_valid(res_valid), .res_ready(res_ready),
    .humidifier_on(humidifier_on), .dryer_on(dryer_on), .ventilator_on(ventilator_on),
    .heater_on(heater_on), .cooler_on(cooler_on),
    .delay_timer_cmd(delay_timer_cmd), .run_timer_cmd(run_timer_cmd),
    .humidity_mode(humidity_mode), .temperature_mode(temperature_mode),
    .handled(handled),
    .mismatches(mismatches), .pending(pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("climate_hysteresis_controller test failed");
    $finish;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        res_ready <= !(idle_en && ($urandom_range(99) < 13));
      end
    end
  end

  // offer one event word and wait for it to be taken
  task automatic send_event(input logic [ActW-1:0] act, input logic [HumW-1:0] hum,
                            input logic signed [TempW-1:0] tmp);
    while (idle_en && ($urandom_range(99) < 13)) begin
      evt_valid <= 1'b0;
      @(posedge clk);
    end
    evt_valid <= 1'b1;
    action <= act;
    humidity <= hum;
    temperature <= tmp;
    @(posedge clk);
    while (!evt_ready) @(posedge clk);
    words_sent++;
  endtask

  // stop offering and wait until every expected word has come back
  task automatic wait_drained();
    evt_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // setup and access phase of one register write, leaving the bus selected
  task automatic write_threshold(input logic [2:0] idx, input logic [DataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apply_thresholds(input thresh_t t, input bit noisy_upper);
    logic [DataW-1:0] pad;
    wait_drained();
    pad = noisy_upper ? $urandom : '0;
    write_threshold(REG_HUMIDIFY_ON_BELOW, {pad[DataW-1:HumW], t.humidify_on_below});
    write_threshold(REG_HUMIDIFY_OFF_ABOVE, {pad[DataW-1:HumW], t.humidify_off_above});
    write_threshold(REG_DRY_OFF_BELOW, {pad[DataW-1:HumW], t.dry_off_below});
    write_threshold(REG_DRY_ON_ABOVE, {pad[DataW-1:HumW], t.dry_on_above});
    pad = noisy_upper ? $urandom : '0;
    write_threshold(REG_HEAT_ON_BELOW, {pad[DataW-1:TempW], t.heat_on_below});
    write_threshold(REG_HEAT_OFF_ABOVE, {pad[DataW-1:TempW], t.heat_off_above});
    write_threshold(REG_COOL_OFF_BELOW, {pad[DataW-1:TempW], t.cool_off_below});
    write_threshold(REG_COOL_ON_ABOVE, {pad[DataW-1:TempW], t.cool_on_above});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    limits_now = t;
    settings_run++;
  endtask

  // sensible hysteresis bands at random positions within the ranges
  function automatic thresh_t ordered_limits();
    thresh_t t;
    int      h0, h1, h2, t0, t1, t2;
    h0 = int'($urandom_range(400));
    h1 = h0 + int'($urandom_range(150));
    h2 = h1 + int'($urandom_range(200));
    t0 = int'($urandom_range(700)) - 400;
    t1 = t0 + int'($urandom_range(300));
    t2 = t1 + int'($urandom_range(300));
    t.humidify_on_below = HumW'(h0);
    t.humidify_off_above = HumW'(h1);
    t.dry_off_below = HumW'(h2);
    t.dry_on_above = HumW'(h2 + int'($urandom_range(1000 - h2)));
    t.heat_on_below = TempW'(t0);
    t.heat_off_above = TempW'(t1);
    t.cool_off_below = TempW'(t2);
    t.cool_on_above = TempW'(t2 + int'($urandom_range(1250 - t2)));
    return t;
  endfunction

  // random event words, values mostly close to a threshold
  task automatic random_phase(input int count, input bit calm, input int stall_at);
    logic [ActW-1:0]          act;
    logic [HumW-1:0]          hum;
    logic signed [TempW-1:0]  tmp;
    int                       pick;
    int                       base;
    idle_en = !calm;
    for (int i = 0; i < count; i++) begin
      if (i == stall_at) hold_req = 1'b1;
      pick = $urandom_range(99);
      if (pick < 46) act = ACT_SENSOR;
      else if (pick < 58) act = ACT_DELAY_EXP;
      else if (pick < 70) act = ACT_RUN_EXP;
      else if (pick < 82) act = ACT_VENT_BTN;
      else if (pick < 94) act = ACT_STOP_BTN;
      else if (pick < 97) act = ACT_RESET;
      else if (pick == 97) act = ACT_SPARE_LO;
      else act = ACT_SPARE_HI;
      // humidity
      pick = $urandom_range(5);
      if (pick == 0) begin
        hum = HumW'($urandom);
      end else begin
        case (pick)
          1: base = int'(limits_now.humidify_on_below);
          2: base = int'(limits_now.humidify_off_above);
          3: base = int'(limits_now.dry_off_below);
          4: base = int'(limits_now.dry_on_above);
          default: base = int'($urandom_range(1000));
        endcase
        hum = HumW'(base + int'($urandom_range(6)) - 3);
      end
      // temperature
      pick = $urandom_range(5);
      if (pick == 0) begin
        tmp = TempW'($urandom);
      end else begin
        case (pick)
          1: base = int'(limits_now.heat_on_below);
          2: base = int'(limits_now.heat_off_above);
          3: base = int'(limits_now.cool_off_below);
          4: base = int'(limits_now.cool_on_above);
          default: base = int'($urandom_range(1650)) - 400;
        endcase
        tmp = TempW'(base + int'($urandom_range(6)) - 3);
      end
      send_event(act, hum, tmp);
    end
    wait_drained();
  endtask

  // stimulus
  initial begin
    thresh_t     t;
    logic [95:0] raw_bits;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    evt_valid <= 1'b0;
    action <= ACT_SENSOR;
    humidity <= '0;
    temperature <= '0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    words_sent = 0;
    settings_run = 1;
    limits_now = {RST_HUMIDIFY_ON_BELOW, RST_HUMIDIFY_OFF_ABOVE, RST_DRY_OFF_BELOW,
                  RST_DRY_ON_ABOVE, RST_HEAT_ON_BELOW, RST_HEAT_OFF_ABOVE,
                  RST_COOL_OFF_BELOW, RST_COOL_ON_ABOVE};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed walk through every transition at the reset thresholds
    send_event(ACT_SENSOR, 10'd0, 12'h800);         // humidify and heat, field minima
    send_event(ACT_SENSOR, 10'd650, 12'sd230);      // both on their off threshold: hold
    send_event(ACT_SENSOR, 10'd651, 12'sd231);      // back to idle from both
    send_event(ACT_SENSOR, 10'd1023, 12'h7FF);      // dry and cool, field maxima
    send_event(ACT_SENSOR, 10'd750, 12'sd260);      // hold
    send_event(ACT_SENSOR, 10'd749, 12'sd259);      // back to idle from both
    send_event(ACT_SENSOR, 10'd600, 12'sd200);      // on idle boundaries: no change
    send_event(ACT_SENSOR, 10'd800, 12'sd290);
    send_event(ACT_DELAY_EXP, 10'h3FF, 12'hFFF);    // idle starts ventilating
    send_event(ACT_VENT_BTN, 10'h155, 12'h555);     // already ventilating: ignored
    send_event(ACT_DELAY_EXP, 10'h2AA, 12'hAAA);
    send_event(ACT_RUN_EXP, 10'd0, 12'h000);        // ventilation ends
    send_event(ACT_RUN_EXP, 10'd5, 12'sd5);         // not ventilating: ignored
    send_event(ACT_STOP_BTN, 10'd5, 12'sd5);
    send_event(ACT_VENT_BTN, 10'd5, 12'sd5);        // button starts ventilation
    send_event(ACT_SENSOR, 10'd599, 12'sd199);      // ventilating to humidifying
    send_event(ACT_SENSOR, 10'd700, 12'sd231);
    send_event(ACT_VENT_BTN, 10'd5, 12'sd5);
    send_event(ACT_STOP_BTN, 10'd5, 12'sd5);        // stop button ends ventilation
    send_event(ACT_DELAY_EXP, 10'd5, 12'sd5);
    send_event(ACT_SENSOR, 10'd801, 12'sd291);      // ventilating to drying
    send_event(ACT_RESET, 10'd5, 12'sd5);           // reset while drying
    send_event(ACT_VENT_BTN, 10'd5, 12'sd5);
    send_event(ACT_RESET, 10'd5, 12'sd5);           // reset while ventilating
    send_event(ACT_SPARE_LO, 10'd1, 12'sd1);        // unused codes
    send_event(ACT_SPARE_HI, 10'd1, 12'sd1);
    send_event(ACT_RESET, 10'd5, 12'sd5);           // reset while idle

    // random phases over several threshold settings
    random_phase(200, 1'b0, 60);
    apply_thresholds({10'd0, 10'd0, 10'd0, 10'd0,
                      -12'sd400, -12'sd400, -12'sd400, -12'sd400}, 1'b0);
    random_phase(150, 1'b0, -1);
    apply_thresholds({10'd1000, 10'd1000, 10'd1000, 10'd1000,
                      12'sd1250, 12'sd1250, 12'sd1250, 12'sd1250}, 1'b0);
    random_phase(150, 1'b0, -1);
    apply_thresholds(ordered_limits(), 1'b0);
    random_phase(250, 1'b1, -1);
    // raw register contents, out of range and inverted bands included
    raw_bits = {$urandom, $urandom, $urandom};
    t = raw_bits[$bits(thresh_t)-1:0];
    apply_thresholds(t, 1'b1);
    random_phase(200, 1'b0, 100);
    apply_thresholds({10'd500, 10'd500, 10'd500, 10'd500,
                      12'sd0, 12'sd0, 12'sd0, 12'sd0}, 1'b0);
    random_phase(150, 1'b0, -1);
    apply_thresholds(ordered_limits(), 1'b0);
    random_phase(200, 1'b0, 30);
    apply_thresholds({RST_HUMIDIFY_ON_BELOW, RST_HUMIDIFY_OFF_ABOVE, RST_DRY_OFF_BELOW,
                      RST_DRY_ON_ABOVE, RST_HEAT_ON_BELOW, RST_HEAT_OFF_ABOVE,
                      RST_COOL_OFF_BELOW, RST_COOL_ON_ABOVE}, 1'b0);
    random_phase(100, 1'b0, -1);

    wait_drained();
    repeat (4) @(posedge clk);
    $display("covered %0d event words across %0d threshold settings", words_sent,
             settings_run);
    $display("with idle gaps, full-rate stretches, long result hold-offs; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("climate_hysteresis_controller test passed");
    end else begin
      $display("climate_hysteresis_controller test failed");
    end
    $finish;
  end

endmodule
